@@ hdl/lifo_stack_with_search_macros.svh @@
// lifo_stack_with_search_macros.svh: assertion macros for the stack checker
// depends on nothing; included by files that assert
`ifndef LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_MACROS_SVH

// same-cycle implication
`define LSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lss assertion failed");

// next-cycle implication
`define LSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lss assertion failed");

`endif

@@ hdl/lss_pkg.sv @@
// lss_pkg: types and codes shared by the stack front end, back end and checker
// depends on nothing
`default_nettype none
package lss_pkg;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [2:0] ST_PUSHED   = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_POPPED   = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FOUND    = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  localparam logic [1:0] K_PUSH   = 2'd0;
  localparam logic [1:0] K_POP    = 2'd1;
  localparam logic [1:0] K_SEARCH = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_value;
    logic [5:0]         position;
    logic [5:0]         occupancy;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t item;
  } qhead_t;

endpackage
`default_nettype wire

@@ hdl/lifo_stack_with_search.sv @@
// lifo_stack_with_search: bounded LIFO stack of 32-bit values with push, pop and search
// depends on lss_pkg, lss_front, lss_back
//
// An item is taken when start is high and busy is low; busy rises only when the
// two-entry command queue is full. Results come at most one per cycle on result
// with done high for that one cycle and cannot be held off. The back end reads
// its stack memory at most once per cycle: a push, a full push, an empty pop or
// a search of an empty stack is answered from the idle state, a pop reads in idle
// and answers from the pop state, and a search over stored entries reads one entry
// per cycle from the top down, then drains the registered read. An unused op
// code gets no result; each result leaves in the cycle after the back end makes it.
`default_nettype none
module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire cmd_t    cmd,
  output logic         busy,
  output logic         done,
  output result_t      result
);

  qhead_t head;
  logic   take;

  lss_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .head  (head),
    .take  (take)
  );

  lss_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .take   (take),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

@@ hdl/lss_front.sv @@
// lss_front: takes items, drops unused op codes and queues the rest
// depends on lss_pkg
`default_nettype none
module lss_front
  import lss_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  input  wire cmd_t   cmd,
  output logic        busy,
  output qhead_t      head,
  input  wire logic   take
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  work_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [FW-1:0]  fill;
  logic           accept;
  logic           push_q;
  logic           pop_q;
  work_t          item_in;

  assign busy   = (fill == FW'(QUEUE_DEPTH));
  assign accept = start && !busy;
  assign push_q = accept && (cmd.op == OP_PUSH || cmd.op == OP_POP || cmd.op == OP_SEARCH);
  assign pop_q  = take && (fill != '0);

  always_comb begin
    item_in.value = cmd.value;
    unique case (cmd.op)
      OP_PUSH:   item_in.kind = K_PUSH;
      OP_POP:    item_in.kind = K_POP;
      OP_SEARCH: item_in.kind = K_SEARCH;
      default:   item_in.kind = K_PUSH;
    endcase
  end

  assign head.valid = (fill != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_q) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_q) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_q) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_q && !pop_q) begin
        fill <= fill + FW'(1);
      end else if (pop_q && !push_q) begin
        fill <= fill - FW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/lss_back.sv @@
// lss_back: stack memory, push, pop and the pipelined search scan
// depends on lss_pkg
`default_nettype none
module lss_back
  import lss_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire qhead_t head,
  output logic        take,
  output logic        done,
  output result_t     result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [31:0]   mem [STACK_DEPTH];
  logic [31:0]   rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [1:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [31:0]   key, key_next;
  logic [AW-1:0] scan_addr, scan_addr_next;
  logic [CW-1:0] issue_pos, issue_pos_next;
  logic          issuing, issuing_next;
  logic          cmp_valid, cmp_valid_next;
  logic [CW-1:0] cmp_pos, cmp_pos_next;
  logic          hold_valid, hold_valid_next;
  logic [CW-1:0] hold_pos, hold_pos_next;
  logic          emit;
  result_t       res;

  always_comb begin
    state_next      = state;
    count_next      = count;
    key_next        = key;
    scan_addr_next  = scan_addr;
    issue_pos_next  = issue_pos;
    issuing_next    = issuing;
    cmp_valid_next  = 1'b0;
    cmp_pos_next    = cmp_pos;
    hold_valid_next = hold_valid;
    hold_pos_next   = hold_pos;
    take            = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = scan_addr;
    wr_en           = 1'b0;
    emit            = 1'b0;
    res             = '0;
    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          take = 1'b1;
          unique case (head.item.kind)
            K_PUSH: begin
              emit     = 1'b1;
              res.last = 1'b1;
              if (count == CW'(STACK_DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
                res.status = ST_PUSHED;
              end
            end
            K_POP: begin
              if (count == '0) begin
                emit       = 1'b1;
                res.last   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
                rd_en      = 1'b1;
                rd_addr    = AW'(count - CW'(1));
                state_next = S_POP;
              end
            end
            K_SEARCH: begin
              if (count == '0) begin
                emit       = 1'b1;
                res.last   = 1'b1;
                res.status = ST_NOTFOUND;
              end else begin
                key_next        = head.item.value;
                scan_addr_next  = AW'(count - CW'(1));
                issue_pos_next  = CW'(1);
                issuing_next    = 1'b1;
                hold_valid_next = 1'b0;
                state_next      = S_SRCH;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_POP: begin
        emit             = 1'b1;
        res.last         = 1'b1;
        res.status       = ST_POPPED;
        res.result_value = rd_data;
        state_next       = S_IDLE;
      end
      S_SRCH: begin
        if (issuing) begin
          rd_en          = 1'b1;
          rd_addr        = scan_addr;
          cmp_valid_next = 1'b1;
          cmp_pos_next   = issue_pos;
          if (scan_addr == '0) begin
            issuing_next = 1'b0;
          end else begin
            scan_addr_next = scan_addr - AW'(1);
            issue_pos_next = issue_pos + CW'(1);
          end
        end
        if (cmp_valid && rd_data == key) begin
          if (hold_valid) begin
            emit         = 1'b1;
            res.status   = ST_FOUND;
            res.position = 6'(hold_pos);
          end
          hold_valid_next = 1'b1;
          hold_pos_next   = cmp_pos;
        end
        if (!issuing && !cmp_valid) begin
          emit       = 1'b1;
          res.last   = 1'b1;
          state_next = S_IDLE;
          if (hold_valid) begin
            res.status   = ST_FOUND;
            res.position = 6'(hold_pos);
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.occupancy = 6'(count_next);
  end

  // stack memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= head.item.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    key       <= key_next;
    scan_addr <= scan_addr_next;
    issue_pos <= issue_pos_next;
    cmp_pos   <= cmp_pos_next;
    hold_pos  <= hold_pos_next;
    result    <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      issuing    <= 1'b0;
      cmp_valid  <= 1'b0;
      hold_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      issuing    <= issuing_next;
      cmp_valid  <= cmp_valid_next;
      hold_valid <= hold_valid_next;
      done       <= emit;
    end
  end

endmodule
`default_nettype wire

@@ hdl/lss_checker.sv @@
// lss_checker: port-level checks on the stack results, bound to the top level
// depends on lss_pkg and lifo_stack_with_search_macros.svh
`default_nettype none
`include "lifo_stack_with_search_macros.svh"
module lss_checker
  import lss_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  logic is_found;
  logic is_empty;
  logic empty_ok;
  logic found_ok;

  assign is_found = (result.status == ST_FOUND);
  assign is_empty = (result.status == ST_EMPTY);
  assign empty_ok = (result.occupancy == 6'd0) && (result.result_value == 32'sd0);
  assign found_ok = (result.position != 6'd0) && (result.occupancy != 6'd0);

  `LSS_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !done && !busy)
  `LSS_ASSERT_IMPL(a_single_last, clk, rst, done && !is_found, result.last)
  `LSS_ASSERT_IMPL(a_pos_found, clk, rst, done && !is_found, result.position == 6'd0)
  `LSS_ASSERT_IMPL(a_empty_clean, clk, rst, done && is_empty, empty_ok)
  `LSS_ASSERT_IMPL(a_found_pos, clk, rst, done && is_found, found_ok)

endmodule

bind lifo_stack_with_search lss_checker u_chk (.*);
`default_nettype wire

@@ dv/tb_lifo_stack_with_search.sv @@
// tb_lifo_stack_with_search: self-checking testbench for the bounded stack with search
// depends on lss_pkg and lifo_stack_with_search; a scoreboard class tracks the stack
// contents and holds the results due for each accepted item
`timescale 1ns / 1ps
module tb_lifo_stack_with_search;
  import lss_pkg::*;

  localparam int DEPTH = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class stack_scoreboard;
    logic [31:0] entries [64];
    int unsigned depth;
    int unsigned fill;
    int errors;
    result_t due_results [$];

    function new(int unsigned d);
      depth = d;
      fill = 0;
      errors = 0;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function void note_cmd(cmd_t c);
      result_t r;
      int unsigned p;
      int hits;
      r = '0;
      r.last = 1'b1;
      hits = 0;
      case (c.op)
        OP_PUSH: begin
          if (fill >= depth) begin
            r.status = ST_FULL;
          end else begin
            entries[fill] = c.value;
            fill++;
            r.status = ST_PUSHED;
          end
          r.occupancy = 6'(fill);
          due_results.push_back(r);
        end
        OP_POP: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            fill--;
            r.status = ST_POPPED;
            r.result_value = entries[fill];
          end
          r.occupancy = 6'(fill);
          due_results.push_back(r);
        end
        OP_SEARCH: begin
          r.occupancy = 6'(fill);
          for (p = 1; p <= fill; p++) begin
            if (entries[fill - p] == c.value) begin
              r.status = ST_FOUND;
              r.position = 6'(p);
              r.last = 1'b0;
              due_results.push_back(r);
              hits++;
            end
          end
          if (hits == 0) begin
            r.status = ST_NOTFOUND;
            r.position = '0;
            r.last = 1'b1;
            due_results.push_back(r);
          end else begin
            r = due_results.pop_back();
            r.last = 1'b1;
            due_results.push_back(r);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      field_check("status", 32'(want.status), 32'(got.status));
      field_check("result_value", want.result_value, got.result_value);
      field_check("position", 32'(want.position), 32'(got.position));
      field_check("occupancy", 32'(want.occupancy), 32'(got.occupancy));
      field_check("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  result_t result;

  stack_scoreboard sb;

  lifo_stack_with_search #(
    .STACK_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (done !== 1'b0) sb.check_result(result);
      if (start && busy === 1'b0) sb.note_cmd(cmd);
    end
  end

  task automatic send_cmd(input logic [1:0] op, input logic [31:0] value);
    cmd_t c;
    c.op = op;
    c.value = value;
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_cycles(input int n);
    cmd_t c;
    repeat (n) begin
      c.op = 2'($urandom_range(0, 3));
      c.value = $urandom;
      @(negedge clk);
      start <= 1'b0;
      cmd <= c;
    end
  endtask

  initial begin : stimulus
    logic [31:0] extremes [4];
    logic [31:0] pool [8];
    logic [31:0] value;
    logic [1:0] op;
    int counted;
    int burst_left;
    int mode;
    int phase_len;
    int pool_n;
    int roll;
    int wait_count;

    extremes[0] = 32'h7fff_ffff;
    extremes[1] = 32'h8000_0000;
    extremes[2] = 32'h0000_0000;
    extremes[3] = 32'hffff_ffff;

    sb = new(DEPTH);
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty-stack cases, ignored op, extremes and repeated matches
    send_cmd(OP_POP, 32'h1234_5678);
    send_cmd(OP_SEARCH, 32'h0000_0000);
    send_cmd(OP_UNUSED, 32'h0000_0000);
    send_cmd(OP_PUSH, 32'h7fff_ffff);
    send_cmd(OP_PUSH, 32'h8000_0000);
    send_cmd(OP_PUSH, 32'h0000_0000);
    send_cmd(OP_PUSH, 32'hffff_ffff);
    send_cmd(OP_PUSH, 32'h8000_0000);
    send_cmd(OP_SEARCH, 32'h8000_0000);
    send_cmd(OP_SEARCH, 32'h7fff_ffff);
    send_cmd(OP_SEARCH, 32'h0000_0001);
    send_cmd(OP_UNUSED, 32'hffff_ffff);
    send_cmd(OP_POP, 32'hffff_ffff);
    send_cmd(OP_SEARCH, 32'hffff_ffff);
    send_cmd(OP_POP, 32'h0000_0000);
    send_cmd(OP_POP, 32'h0000_0000);
    send_cmd(OP_POP, 32'h0000_0000);
    send_cmd(OP_POP, 32'h0000_0000);
    send_cmd(OP_POP, 32'h0000_0000);
    send_cmd(OP_SEARCH, 32'h0000_0000);
    idle_cycles(40);

    // phases biased toward filling, draining or a mix, values mostly from a small pool
    counted = 0;
    burst_left = $urandom_range(1, 12);
    while (counted < 290) begin
      mode = $urandom_range(0, 2);
      phase_len = $urandom_range(30, 55);
      if (phase_len > 290 - counted) phase_len = 290 - counted;
      pool_n = $urandom_range(1, 6);
      for (int i = 0; i < pool_n; i++) begin
        pool[i] = ($urandom_range(0, 3) == 0) ? extremes[$urandom_range(0, 3)] : $urandom;
      end
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0: op = (roll < 75) ? OP_PUSH : (roll < 80) ? OP_POP :
                  (roll < 96) ? OP_SEARCH : OP_UNUSED;
          1: op = (roll < 70) ? OP_POP : (roll < 80) ? OP_PUSH :
                  (roll < 96) ? OP_SEARCH : OP_UNUSED;
          default: op = (roll < 40) ? OP_PUSH : (roll < 75) ? OP_POP :
                        (roll < 96) ? OP_SEARCH : OP_UNUSED;
        endcase
        value = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, pool_n - 1)] : $urandom;
        send_cmd(op, value);
        counted++;
        burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
          burst_left = $urandom_range(1, 16);
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;

    wait_count = 0;
    while (sb.outstanding() != 0 && wait_count < 5000) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (60) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      if (sb.outstanding() != 0) $display("%0t: %0d results never arrived", $time,
                                          sb.outstanding());
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
